### rtl/moi_pkg.sv
// Shared types, widths, register codes and the sine function for the odometry integrator.
package moi_pkg;

    // Defaults for top-level parameters
    localparam int SINE_TABLE_SIZE_DEF = 1024;
    localparam int POSITION_BITS_DEF   = 48;

    // Field widths
    localparam int PULSE_W   = 16;
    localparam int YAW_W     = 16;
    localparam int HEAD_W    = 16;
    localparam int POS_OUT_W = 48;
    localparam int VEL_W     = 32;
    localparam int DPP_W     = 24;
    localparam int RATE_W    = 14;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HZ        = 2'd1;
    localparam logic [DPP_W-1:0]     DPP_RESET          = 24'd335544;
    localparam logic [RATE_W-1:0]    RATE_RESET         = 14'd100;

    // Datapath widths
    localparam int SUM_W   = 18;                 // sum of four pulse counts
    localparam int COEF_W  = 16;                 // Q1.15 sine / cosine
    localparam int DIST_W  = SUM_W + DPP_W + 1;  // body step, 2^-26 cm
    localparam int ROT_W   = DIST_W + COEF_W;    // rotated step, 2^-41 cm
    localparam int VSTEP_W = ROT_W - 17;         // step in 2^-24 cm
    localparam int VMUL_W  = VSTEP_W + RATE_W + 1;

    localparam int POS_SHIFT  = 25;
    localparam int VEL_SHIFT  = 17;
    localparam int RATE_SHIFT = 16;

    localparam int YAW_FULL = 36000;

    // Angles in Q30 radians
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint Q30_ONE     = 64'sd1073741824;

    typedef struct packed {
        logic load;   // capture kinematic sums and heading
        logic mul;    // scale by travel per pulse, compute table index
        logic rom;    // read sine and cosine
    } front_ctrl_t;

    typedef struct packed {
        logic mul;    // two rotation products
        logic sum;    // add products
        logic acc;    // integrate position, scale velocity
    } lane_ctrl_t;

    // Q1.15 sine of a Q30 angle in [0, 2*pi); folded to the first quadrant,
    // Taylor series to x^13 with each term truncated toward zero.
    function automatic logic signed [COEF_W-1:0] sin_q15(input longint ang);
        longint a;
        longint x2;
        longint term;
        longint sum;
        longint r;
        logic   neg;
        a   = ang;
        neg = 1'b0;
        if (a > PI_Q30)
        begin
            a   = a - PI_Q30;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q30)
            a = PI_Q30 - a;
        if (a < 0)
            a = 0;
        x2   = (a * a) / Q30_ONE;
        term = a;
        sum  = a;
        term = -((term * x2) / Q30_ONE);
        term = term / 6;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE);
        term = term / 20;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE);
        term = term / 42;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE);
        term = term / 72;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE);
        term = term / 110;
        sum  = sum + term;
        term = -((term * x2) / Q30_ONE);
        term = term / 156;
        sum  = sum + term;
        if (sum < 0)
            sum = 0;
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (neg)
            r = -r;
        return COEF_W'(r);
    endfunction

endpackage

### rtl/moi_ifs.sv
// Valid/ready channel interfaces for wheel samples and pose results.
interface moi_in_if import moi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PULSE_W-1:0] pulse_lf;
    logic signed [PULSE_W-1:0] pulse_lb;
    logic signed [PULSE_W-1:0] pulse_rb;
    logic signed [PULSE_W-1:0] pulse_rf;
    logic [YAW_W-1:0]          yaw_cd;

    modport source (output valid, pulse_lf, pulse_lb, pulse_rb, pulse_rf, yaw_cd,
                    input ready);
    modport sink   (input valid, pulse_lf, pulse_lb, pulse_rb, pulse_rf, yaw_cd,
                    output ready);
endinterface

interface moi_out_if import moi_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [POS_OUT_W-1:0] pos_x_out;
    logic signed [POS_OUT_W-1:0] pos_y_out;
    logic signed [VEL_W-1:0]     vel_x;
    logic signed [VEL_W-1:0]     vel_y;
    logic [HEAD_W-1:0]           heading_cd;

    modport source (output valid, pos_x_out, pos_y_out, vel_x, vel_y, heading_cd,
                    input ready);
    modport sink   (input valid, pos_x_out, pos_y_out, vel_x, vel_y, heading_cd,
                    output ready);
endinterface

### rtl/moi_front.sv
// Front end: wheel kinematics, heading, table index and sine/cosine lookup.
module moi_front
    import moi_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
)
(
    input  logic                      clk,
    input  front_ctrl_t               ctrl,
    input  logic signed [PULSE_W-1:0] pulse_lf,
    input  logic signed [PULSE_W-1:0] pulse_lb,
    input  logic signed [PULSE_W-1:0] pulse_rb,
    input  logic signed [PULSE_W-1:0] pulse_rf,
    input  logic [YAW_W-1:0]          yaw_cd,
    input  logic [DPP_W-1:0]          dist_per_pulse,
    output logic signed [DIST_W-1:0]  fwd,
    output logic signed [DIST_W-1:0]  lat,
    output logic signed [COEF_W-1:0]  sin_q,
    output logic signed [COEF_W-1:0]  cos_q,
    output logic signed [COEF_W-1:0]  nsin_q,
    output logic [HEAD_W-1:0]         heading_cd
);

    localparam int IDX_W       = $clog2(SINE_TABLE_SIZE);
    localparam int RECIP_SHIFT = 31;
    localparam int IPROD_W     = YAW_W + 32;
    // ceil(2^31 * SIZE / 36000): exact floor for any heading below 36000
    localparam longint RECIP_L = ((64'sd1 <<< RECIP_SHIFT) * longint'(SINE_TABLE_SIZE)
                                  + longint'(YAW_FULL) - 64'sd1) / longint'(YAW_FULL);
    localparam logic [31:0]      RECIP  = RECIP_L[31:0];
    localparam logic [YAW_W-1:0] YAW_FW = YAW_W'(YAW_FULL);

    logic signed [COEF_W-1:0] sin_rom [SINE_TABLE_SIZE];
    logic signed [COEF_W-1:0] cos_rom [SINE_TABLE_SIZE];

    for (genvar g = 0; g < SINE_TABLE_SIZE; g++)
    begin : g_rom
        localparam longint ANG   = (TWO_PI_Q30 * longint'(g)) / longint'(SINE_TABLE_SIZE);
        localparam longint ANG_R = ANG + HALF_PI_Q30;
        localparam longint ANG_C = (ANG_R >= TWO_PI_Q30) ? ANG_R - TWO_PI_Q30 : ANG_R;
        assign sin_rom[g] = sin_q15(ANG);
        assign cos_rom[g] = sin_q15(ANG_C);
    end

    logic [YAW_W-1:0]         yaw_wrap;
    logic [HEAD_W-1:0]        heading_next;
    logic signed [SUM_W-1:0]  sum_f_next;
    logic signed [SUM_W-1:0]  sum_l_next;
    logic [IPROD_W-1:0]       idx_prod;

    logic signed [SUM_W-1:0]  sum_f_reg;
    logic signed [SUM_W-1:0]  sum_l_reg;
    logic [HEAD_W-1:0]        heading_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DIST_W-1:0] fwd_reg;
    logic signed [DIST_W-1:0] lat_reg;
    logic signed [COEF_W-1:0] sin_reg;
    logic signed [COEF_W-1:0] cos_reg;
    logic signed [COEF_W-1:0] nsin_reg;

    always_comb
    begin
        yaw_wrap     = (yaw_cd >= YAW_FW) ? yaw_cd - YAW_FW : yaw_cd;
        heading_next = (yaw_wrap == '0) ? '0 : HEAD_W'(YAW_FW - yaw_wrap);
        sum_f_next   = SUM_W'(pulse_lf) + SUM_W'(pulse_lb) + SUM_W'(pulse_rb)
                     + SUM_W'(pulse_rf);
        sum_l_next   = (SUM_W'(pulse_lf) + SUM_W'(pulse_rb))
                     - (SUM_W'(pulse_lb) + SUM_W'(pulse_rf));
        idx_prod     = IPROD_W'(heading_reg) * IPROD_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sum_f_reg   <= sum_f_next;
            sum_l_reg   <= sum_l_next;
            heading_reg <= heading_next;
        end
        if (ctrl.mul)
        begin
            fwd_reg <= DIST_W'(sum_f_reg) * DIST_W'($signed({1'b0, dist_per_pulse}));
            lat_reg <= DIST_W'(sum_l_reg) * DIST_W'($signed({1'b0, dist_per_pulse}));
            idx_reg <= idx_prod[RECIP_SHIFT +: IDX_W];
        end
        if (ctrl.rom)
        begin
            sin_reg  <= sin_rom[idx_reg];
            cos_reg  <= cos_rom[idx_reg];
            nsin_reg <= -sin_rom[idx_reg];
        end
    end

    assign fwd        = fwd_reg;
    assign lat        = lat_reg;
    assign sin_q      = sin_reg;
    assign cos_q      = cos_reg;
    assign nsin_q     = nsin_reg;
    assign heading_cd = heading_reg;

endmodule

### rtl/moi_lane.sv
// One world-axis lane: rotation products, position integrator and velocity scaling.
module moi_lane
    import moi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctrl_t               ctrl,
    input  logic signed [DIST_W-1:0] lat,
    input  logic signed [DIST_W-1:0] fwd,
    input  logic signed [COEF_W-1:0] lat_coef,
    input  logic signed [COEF_W-1:0] fwd_coef,
    input  logic [RATE_W-1:0]        rate_hz,
    output logic [POSITION_BITS-1:0] pos,
    output logic signed [VEL_W-1:0]  vel
);

    localparam logic signed [VMUL_W-1:0] VEL_MAX = VMUL_W'(64'sd2147483647);
    localparam logic signed [VMUL_W-1:0] VEL_MIN = VMUL_W'(-64'sd2147483648);

    logic signed [ROT_W-1:0]   p_lat_reg;
    logic signed [ROT_W-1:0]   p_fwd_reg;
    logic signed [ROT_W-1:0]   rot_reg;
    logic signed [VMUL_W-1:0]  vmul_reg;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_next;
    logic signed [VSTEP_W-1:0] vstep;
    logic signed [VMUL_W-1:0]  vshift;

    always_comb
    begin
        pos_next = pos_reg + POSITION_BITS'(rot_reg >>> POS_SHIFT);
        vstep    = VSTEP_W'(rot_reg >>> VEL_SHIFT);
        vshift   = vmul_reg >>> RATE_SHIFT;
        if (vshift > VEL_MAX)
            vel = VEL_W'(VEL_MAX);
        else if (vshift < VEL_MIN)
            vel = VEL_W'(VEL_MIN);
        else
            vel = VEL_W'(vshift);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            p_lat_reg <= ROT_W'(lat) * ROT_W'(lat_coef);
            p_fwd_reg <= ROT_W'(fwd) * ROT_W'(fwd_coef);
        end
        if (ctrl.sum)
            rot_reg <= p_lat_reg + p_fwd_reg;
        if (ctrl.acc)
            vmul_reg <= VMUL_W'(vstep) * VMUL_W'($signed({1'b0, rate_hz}));
    end

    // Wrapping position integrator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (ctrl.acc)
            pos_reg <= pos_next;
    end

    assign pos = pos_reg;

endmodule

### rtl/mecanum_odometry_integrator_unit.sv
// Top level of the mecanum wheel odometry integrator.
//
//  Channel  Dir  Handshake          Beat contents
//  -------  ---  -----------------  ---------------------------------------------
//  wheel    in   valid/ready        pulse_lf, pulse_lb, pulse_rb, pulse_rf, yaw_cd
//  pose     out  valid/ready        pos_x_out, pos_y_out, vel_x, vel_y, heading_cd
//  cfg      in   cfg_we only        cfg_idx, cfg_data (0: dist_per_pulse, 1: rate_hz)
//
// One wheel beat is in flight at a time. Its pose beat is built in order from the
// edge that accepts it: kinematic sums at acceptance, then scale multiply plus table
// index multiply, sine/cosine table read, lane multiplies, lane add, integrate and
// velocity multiply, and the output register load. The next wheel beat is taken the
// cycle after the load; no new wheel beat is taken before the last one is loaded.
// The output register holds a finished pose while the next wheel beat is worked
// on; a stalled pose sink holds the sequencer only at the load step.
// Reset clears the sequencer, the output valid and both position integrators,
// and restores the configuration registers to their reset values.
module mecanum_odometry_integrator_unit
    import moi_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    moi_in_if.sink                wheel,
    moi_out_if.source             pose
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_IDX  = 7'b0000010,
        ST_ROM  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_VEL  = 7'b0100000,
        ST_LOAD = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DPP_W-1:0]  dpp_reg;
    logic [DPP_W-1:0]  dpp_next;
    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] rate_next;

    logic accept;
    logic load;

    front_ctrl_t front_ctrl;
    lane_ctrl_t  lane_ctrl;

    logic signed [DIST_W-1:0] fwd;
    logic signed [DIST_W-1:0] lat;
    logic signed [COEF_W-1:0] sin_q;
    logic signed [COEF_W-1:0] cos_q;
    logic signed [COEF_W-1:0] nsin_q;
    logic [HEAD_W-1:0]        heading;

    logic [POSITION_BITS-1:0] pos_x;
    logic [POSITION_BITS-1:0] pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [POS_OUT_W-1:0] pos_x_reg;
    logic signed [POS_OUT_W-1:0] pos_y_reg;
    logic signed [VEL_W-1:0]     vel_x_reg;
    logic signed [VEL_W-1:0]     vel_y_reg;
    logic [HEAD_W-1:0]           heading_reg;

    // Configuration writes; unknown indexes drop
    always_comb
    begin
        dpp_next  = dpp_reg;
        rate_next = rate_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_DIST_PER_PULSE: dpp_next  = cfg_data[DPP_W-1:0];
                REG_RATE_HZ:        rate_next = cfg_data[RATE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpp_reg  <= DPP_RESET;
            rate_reg <= RATE_RESET;
        end
        else
        begin
            dpp_reg  <= dpp_next;
            rate_reg <= rate_next;
        end
    end

    // Sequencer: take a beat only when idle, hold at the load step on a stall
    assign wheel.ready = (state_reg == ST_IDLE);
    assign accept      = wheel.valid && wheel.ready;
    assign load        = (state_reg == ST_LOAD) && (!out_valid_reg || pose.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (wheel.valid) state_next = ST_IDX;
            ST_IDX:  state_next = ST_ROM;
            ST_ROM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_VEL;
            ST_VEL:  state_next = ST_LOAD;
            ST_LOAD: if (load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        front_ctrl.load = accept;
        front_ctrl.mul  = (state_reg == ST_IDX);
        front_ctrl.rom  = (state_reg == ST_ROM);
        lane_ctrl.mul   = (state_reg == ST_MUL);
        lane_ctrl.sum   = (state_reg == ST_SUM);
        lane_ctrl.acc   = (state_reg == ST_VEL);
    end

    moi_front #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_front (
        .clk            (clk),
        .ctrl           (front_ctrl),
        .pulse_lf       (wheel.pulse_lf),
        .pulse_lb       (wheel.pulse_lb),
        .pulse_rb       (wheel.pulse_rb),
        .pulse_rf       (wheel.pulse_rf),
        .yaw_cd         (wheel.yaw_cd),
        .dist_per_pulse (dpp_reg),
        .fwd            (fwd),
        .lat            (lat),
        .sin_q          (sin_q),
        .cos_q          (cos_q),
        .nsin_q         (nsin_q),
        .heading_cd     (heading)
    );

    // x lane: lat*cos - fwd*sin
    moi_lane #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .lat      (lat),
        .fwd      (fwd),
        .lat_coef (cos_q),
        .fwd_coef (nsin_q),
        .rate_hz  (rate_reg),
        .pos      (pos_x),
        .vel      (vel_x)
    );

    // y lane: lat*sin + fwd*cos
    moi_lane #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .lat      (lat),
        .fwd      (fwd),
        .lat_coef (sin_q),
        .fwd_coef (cos_q),
        .rate_hz  (rate_reg),
        .pos      (pos_y),
        .vel      (vel_y)
    );

    // Merge both lanes and the heading into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (pose.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // Position keeps the integrator's low bits, zero-filled if narrower
            pos_x_reg   <= POS_OUT_W'(pos_x);
            pos_y_reg   <= POS_OUT_W'(pos_y);
            vel_x_reg   <= vel_x;
            vel_y_reg   <= vel_y;
            heading_reg <= heading;
        end
    end

    assign pose.valid      = out_valid_reg;
    assign pose.pos_x_out  = pos_x_reg;
    assign pose.pos_y_out  = pos_y_reg;
    assign pose.vel_x      = vel_x_reg;
    assign pose.vel_y      = vel_y_reg;
    assign pose.heading_cd = heading_reg;

endmodule

### rtl/moi_checker.sv
// Port-level assertions for the odometry integrator, bound to the top level.
module moi_checker
    import moi_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [POS_OUT_W-1:0] pos_x_out,
    input logic signed [POS_OUT_W-1:0] pos_y_out,
    input logic signed [VEL_W-1:0]     vel_x,
    input logic signed [VEL_W-1:0]     vel_y,
    input logic [HEAD_W-1:0]           heading_cd
);

    // A stalled pose beat holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x_out) && $stable(pos_y_out)
            && $stable(vel_x) && $stable(vel_y) && $stable(heading_cd))
        else $error("pose beat changed while stalled");

    // Only one wheel beat in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("wheel beat taken while another is in flight");

    // A pose beat cannot appear the cycle after a wheel beat is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("pose beat appeared too early");

    // Reported heading stays within one turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_cd < HEAD_W'(YAW_FULL))
        else $error("heading out of range");

endmodule

bind mecanum_odometry_integrator_unit moi_checker u_moi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (wheel.valid),
    .in_ready   (wheel.ready),
    .out_valid  (pose.valid),
    .out_ready  (pose.ready),
    .pos_x_out  (pose.pos_x_out),
    .pos_y_out  (pose.pos_y_out),
    .vel_x      (pose.vel_x),
    .vel_y      (pose.vel_y),
    .heading_cd (pose.heading_cd)
);

### sim/tb_mecanum_odometry_integrator_unit.sv
// Self-checking testbench for the mecanum odometry integrator: predicts every pose beat.
`timescale 1ns / 1ps

module tb_mecanum_odometry_integrator_unit;
    import moi_pkg::*;

    // Run limits and pacing
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_IDLE      = 18;
    localparam int unsigned SETTLE_CYCLES = 12;     // quiet time after the last predicted pose beat
    localparam int unsigned PHASE_ITEMS   = 300;
    localparam int unsigned HOLD_CYCLES   = 250;    // long pose stall to back up the wheel side

    // Register indexes the block does not decode; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Largest travel per pulse and the widest rate the register field holds
    localparam logic [CFG_DATA_W-1:0] DPP_MAX   = 24'hFFFFFF;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES  = 24'hFFFFFF;
    localparam logic [CFG_DATA_W-1:0] RATE_ZERO = 24'hFFC000;  // upper bits set, field is 0

    typedef struct {
        logic signed [POS_OUT_W-1:0] pos_x;
        logic signed [POS_OUT_W-1:0] pos_y;
        logic signed [VEL_W-1:0]     vel_x;
        logic signed [VEL_W-1:0]     vel_y;
        logic [HEAD_W-1:0]           heading;
    } pose_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    moi_in_if  wheel_ch ();
    moi_out_if pose_ch ();

    mecanum_odometry_integrator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .wheel    (wheel_ch),
        .pose     (pose_ch)
    );

    // Shadow of the configuration registers and the two position integrators
    longint                       dpp_model;
    longint                       rate_model;
    logic [POSITION_BITS_DEF-1:0] odo_x_acc;
    logic [POSITION_BITS_DEF-1:0] odo_y_acc;

    // Pose beats predicted at wheel acceptance, oldest first
    pose_beat_t pose_due_q [$];

    int unsigned fail_count;
    int unsigned cycle_count;
    bit          wheel_idle_en;
    bit          pose_idle_en;
    int unsigned pose_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Kill the run if the block hangs somewhere
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_mecanum_odometry_integrator_unit NOT OK");
            $finish;
        end
    end

    // Draw the idle cycles for one beat: none when disabled, else a quarter of the draws force no gap
    function automatic int unsigned draw_idle(input bit enable);
        if (!enable || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Q1.15 sine of a Q30 angle in [0, 2*pi): fold to the first quadrant with a sign,
    // sum the odd Taylor terms to x^13 with every term truncated toward zero, then round.
    function automatic longint q15_sine(input longint angle);
        longint a;
        longint x2;
        longint term;
        longint total;
        longint r;
        bit     neg;
        int     k;
        a   = angle;
        neg = 1'b0;
        if (a > PI_Q30)
        begin
            a   = a - PI_Q30;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q30)
            a = PI_Q30 - a;
        if (a < 0)
            a = 0;
        x2    = (a * a) / Q30_ONE;
        term  = a;
        total = a;
        for (k = 1; k <= 6; k++)
        begin
            term  = -((term * x2) / Q30_ONE);
            term  = term / longint'((2 * k) * (2 * k + 1));
            total = total + term;
        end
        if (total < 0)
            total = 0;
        r = (total + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        return neg ? -r : r;
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Odometry predictor: on every accepted wheel beat run the kinematics, rotate the
    // step by the heading, integrate it and queue the pose beat that must come out.
    always @(posedge clk)
    begin : odometry_predictor
        longint     lf;
        longint     lb;
        longint     rb;
        longint     rf;
        longint     yaw;
        longint     heading;
        longint     idx;
        longint     fwd;
        longint     lat;
        longint     ang;
        longint     ang_c;
        longint     s;
        longint     c;
        longint     rx;
        longint     ry;
        longint     step_x;
        longint     step_y;
        longint     vx;
        longint     vy;
        pose_beat_t beat;
        if (wheel_ch.valid && wheel_ch.ready)
        begin
            lf  = wheel_ch.pulse_lf;
            lb  = wheel_ch.pulse_lb;
            rb  = wheel_ch.pulse_rb;
            rf  = wheel_ch.pulse_rf;
            // Out-of-range yaw folds back into one turn before the direction flip
            yaw     = longint'(wheel_ch.yaw_cd) % YAW_FULL;
            heading = (YAW_FULL - yaw) % YAW_FULL;
            idx     = (heading * SINE_TABLE_SIZE_DEF) / YAW_FULL;
            // Body step in 2^-26 cm; the quarter of the wheel sums is in the units
            fwd = (lf + lb + rb + rf) * dpp_model;
            lat = ((lf + rb) - (lb + rf)) * dpp_model;
            // Table angle, and the cosine as the sine a quarter turn on
            ang   = (TWO_PI_Q30 * idx) / SINE_TABLE_SIZE_DEF;
            ang_c = ang + HALF_PI_Q30;
            if (ang_c >= TWO_PI_Q30)
                ang_c = ang_c - TWO_PI_Q30;
            s  = q15_sine(ang);
            c  = q15_sine(ang_c);
            rx = lat * c - fwd * s;
            ry = lat * s + fwd * c;
            // Floor shifts: positions wrap, velocities saturate
            step_x    = rx >>> POS_SHIFT;
            step_y    = ry >>> POS_SHIFT;
            odo_x_acc = odo_x_acc + step_x[POSITION_BITS_DEF-1:0];
            odo_y_acc = odo_y_acc + step_y[POSITION_BITS_DEF-1:0];
            vx = clamp_s32(((rx >>> VEL_SHIFT) * rate_model) >>> RATE_SHIFT);
            vy = clamp_s32(((ry >>> VEL_SHIFT) * rate_model) >>> RATE_SHIFT);
            beat.pos_x   = odo_x_acc[POS_OUT_W-1:0];
            beat.pos_y   = odo_y_acc[POS_OUT_W-1:0];
            beat.vel_x   = vx[VEL_W-1:0];
            beat.vel_y   = vy[VEL_W-1:0];
            beat.heading = heading[HEAD_W-1:0];
            pose_due_q.push_back(beat);
        end
    end

    // Compare each accepted pose beat with the oldest prediction, field by field
    always @(posedge clk)
    begin : pose_checker
        pose_beat_t want;
        if (pose_ch.valid && pose_ch.ready)
        begin
            if (pose_due_q.size() == 0)
            begin
                $error("pose beat with no wheel beat outstanding");
                fail_count++;
            end
            else
            begin
                want = pose_due_q.pop_front();
                if (pose_ch.pos_x_out !== want.pos_x)
                begin
                    $error("pos_x_out: expected %0d, got %0d", want.pos_x, pose_ch.pos_x_out);
                    fail_count++;
                end
                if (pose_ch.pos_y_out !== want.pos_y)
                begin
                    $error("pos_y_out: expected %0d, got %0d", want.pos_y, pose_ch.pos_y_out);
                    fail_count++;
                end
                if (pose_ch.vel_x !== want.vel_x)
                begin
                    $error("vel_x: expected %0d, got %0d", want.vel_x, pose_ch.vel_x);
                    fail_count++;
                end
                if (pose_ch.vel_y !== want.vel_y)
                begin
                    $error("vel_y: expected %0d, got %0d", want.vel_y, pose_ch.vel_y);
                    fail_count++;
                end
                if (pose_ch.heading_cd !== want.heading)
                begin
                    $error("heading_cd: expected %0d, got %0d", want.heading,
                           pose_ch.heading_cd);
                    fail_count++;
                end
            end
        end
    end

    // Pose sink: before each beat stall for a random count, or for the long hold when
    // a test asks for one, then keep ready high until a beat goes through.
    initial
    begin : pose_sink
        int unsigned wait_cycles;
        pose_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (pose_hold_cycles != 0)
            begin
                wait_cycles      = pose_hold_cycles;
                pose_hold_cycles = 0;
            end
            else
                wait_cycles = draw_idle(pose_idle_en);
            if (wait_cycles != 0)
            begin
                pose_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pose_ch.ready <= 1'b1;
            @(posedge clk);
            while (!pose_ch.valid)
                @(posedge clk);
        end
    end

    // Offer one wheel beat after a random gap and hold it until the block takes it.
    // Valid stays high on return so back-to-back beats need no second assignment.
    task automatic send_wheel_beat(input logic signed [PULSE_W-1:0] lf,
                                   input logic signed [PULSE_W-1:0] lb,
                                   input logic signed [PULSE_W-1:0] rb,
                                   input logic signed [PULSE_W-1:0] rf,
                                   input logic [YAW_W-1:0]          yaw);
        int unsigned gap;
        gap = draw_idle(wheel_idle_en);
        if (gap != 0)
        begin
            wheel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        wheel_ch.valid    <= 1'b1;
        wheel_ch.pulse_lf <= lf;
        wheel_ch.pulse_lb <= lb;
        wheel_ch.pulse_rb <= rb;
        wheel_ch.pulse_rf <= rf;
        wheel_ch.yaw_cd   <= yaw;
        @(posedge clk);
        while (!wheel_ch.ready)
            @(posedge clk);
    endtask

    // Half plausible driving (forward plus strafe with encoder jitter), else raw
    // 16-bit noise and rail values; yaw now and then past one full turn.
    task automatic send_random_sample();
        logic signed [PULSE_W-1:0] p [4];
        logic [YAW_W-1:0]          yaw;
        int                        drive;
        int                        strafe;
        int                        k;
        int unsigned               style;
        style  = $urandom_range(0, 9);
        drive  = int'($urandom_range(0, 1200)) - 600;
        strafe = int'($urandom_range(0, 600)) - 300;
        for (k = 0; k < 4; k++)
        begin
            if (style < 5)
                p[k] = PULSE_W'(drive + ((k == 0 || k == 2) ? strafe : -strafe)
                                + int'($urandom_range(0, 20)) - 10);
            else if (style < 9)
                p[k] = PULSE_W'($urandom());
            else
                case ($urandom_range(0, 3))
                    0:       p[k] = 16'sh8000;
                    1:       p[k] = 16'sh7FFF;
                    2:       p[k] = 16'sh0000;
                    default: p[k] = -16'sd1;
                endcase
        end
        if ($urandom_range(0, 6) == 0)
            yaw = YAW_W'($urandom_range(0, 65535));
        else
            yaw = YAW_W'($urandom_range(0, YAW_FULL - 1));
        send_wheel_beat(p[0], p[1], p[2], p[3], yaw);
    endtask

    // Write one register and mirror it; spare indexes leave the shadow alone
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DIST_PER_PULSE: dpp_model  = longint'(data[DPP_W-1:0]);
            REG_RATE_HZ:        rate_model = longint'(data[RATE_W-1:0]);
            default:            ;
        endcase
    endtask

    // Drop valid, wait for every predicted pose beat, then let the pipe go quiet
    task automatic settle_pipeline();
        wheel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pose_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset configuration: zero motion, rails on all wheels, pure strafe both ways,
    // every quadrant of the heading, and yaw at and past a full turn.
    task automatic test_kinematic_corners();
        wheel_idle_en = 1'b1;
        pose_idle_en  = 1'b1;
        send_wheel_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_wheel_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0);
        send_wheel_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd0);
        send_wheel_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'd0);
        send_wheel_beat(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd27000);
        send_wheel_beat(16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'd9000);
        send_wheel_beat(16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'd18000);
        send_wheel_beat(16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'd35999);
        send_wheel_beat(16'sd10, -16'sd10, 16'sd10, -16'sd10, 16'd36000);
        send_wheel_beat(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'hFFFF);
        send_wheel_beat(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'd1);
        settle_pipeline();
    endtask

    // Register extremes: largest travel with the widest rate (velocity saturates),
    // zero rate, writes to undecoded indexes, zero travel and the slowest rate.
    task automatic test_register_extremes();
        write_reg(REG_DIST_PER_PULSE, DPP_MAX);
        write_reg(REG_RATE_HZ, ALL_ONES);
        send_wheel_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd4500);
        send_wheel_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd31500);
        send_wheel_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'd13500);
        settle_pipeline();
        write_reg(REG_RATE_HZ, RATE_ZERO);
        send_wheel_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd22500);
        send_wheel_beat(16'sd300, -16'sd200, 16'sd300, -16'sd200, 16'd100);
        settle_pipeline();
        // Neither of these may land in a register
        write_reg(REG_SPARE_2, 24'h000000);
        write_reg(REG_SPARE_3, 24'h00ABCD);
        send_wheel_beat(16'sd1000, 16'sd900, 16'sd1100, 16'sd800, 16'd7000);
        settle_pipeline();
        write_reg(REG_DIST_PER_PULSE, 24'd0);
        write_reg(REG_RATE_HZ, 24'd1);
        send_wheel_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd12345);
        settle_pipeline();
    endtask

    // Random traffic in phases; each phase picks a configuration and an idling mix,
    // one of them with no idling on either side.
    task automatic test_random_traffic();
        int          ph;
        int unsigned n;
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_DIST_PER_PULSE, CFG_DATA_W'($urandom_range(0, 16777215)));
                    write_reg(REG_RATE_HZ, CFG_DATA_W'($urandom_range(1, 10000)));
                    wheel_idle_en = 1'b1;
                    pose_idle_en  = 1'b1;
                end
                1:
                begin
                    write_reg(REG_DIST_PER_PULSE, DPP_MAX);
                    write_reg(REG_RATE_HZ, 24'd10000);
                    wheel_idle_en = 1'b0;
                    pose_idle_en  = 1'b0;
                end
                2:
                begin
                    write_reg(REG_DIST_PER_PULSE, CFG_DATA_W'($urandom_range(1, 1000)));
                    write_reg(REG_RATE_HZ, 24'd1);
                    wheel_idle_en = 1'b1;
                    pose_idle_en  = 1'b0;
                end
                3:
                begin
                    write_reg(REG_DIST_PER_PULSE, CFG_DATA_W'($urandom()));
                    write_reg(REG_RATE_HZ, CFG_DATA_W'($urandom()));
                    wheel_idle_en = 1'b0;
                    pose_idle_en  = 1'b1;
                end
                4:
                begin
                    write_reg(REG_DIST_PER_PULSE, CFG_DATA_W'(DPP_RESET));
                    write_reg(REG_RATE_HZ, CFG_DATA_W'(RATE_RESET));
                    wheel_idle_en = 1'b1;
                    pose_idle_en  = 1'b1;
                end
                default:
                begin
                    write_reg(REG_DIST_PER_PULSE, CFG_DATA_W'($urandom_range(0, 16777215)));
                    write_reg(REG_RATE_HZ, ALL_ONES);
                    wheel_idle_en = 1'b1;
                    pose_idle_en  = 1'b1;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_sample();
            settle_pipeline();
        end
    endtask

    // Stall the pose side for a long stretch while wheel beats keep coming, so the
    // output register fills and the block has to push back on its input.
    task automatic test_output_backpressure();
        int unsigned n;
        wheel_idle_en    = 1'b0;
        pose_idle_en     = 1'b1;
        pose_hold_cycles = HOLD_CYCLES;
        for (n = 0; n < 20; n++)
            send_random_sample();
        settle_pipeline();
    endtask

    // Send one beat at a time, each only after the previous pose has come out
    task automatic test_paced_sender();
        int unsigned n;
        wheel_idle_en = 1'b1;
        pose_idle_en  = 1'b1;
        for (n = 0; n < 30; n++)
        begin
            send_random_sample();
            settle_pipeline();
        end
    endtask

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_DIST_PER_PULSE;
        cfg_data          <= '0;
        wheel_ch.valid    <= 1'b0;
        wheel_ch.pulse_lf <= '0;
        wheel_ch.pulse_lb <= '0;
        wheel_ch.pulse_rb <= '0;
        wheel_ch.pulse_rf <= '0;
        wheel_ch.yaw_cd   <= '0;
        dpp_model         = longint'(DPP_RESET);
        rate_model        = longint'(RATE_RESET);
        odo_x_acc         = '0;
        odo_y_acc         = '0;
        fail_count        = 0;
        cycle_count       = 0;
        wheel_idle_en     = 1'b0;
        pose_idle_en      = 1'b0;
        pose_hold_cycles  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_kinematic_corners();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_paced_sender();

        settle_pipeline();
        if (fail_count == 0)
            $display("tb_mecanum_odometry_integrator_unit OK");
        else
            $display("tb_mecanum_odometry_integrator_unit NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/moi_pkg.sv
rtl/moi_ifs.sv
rtl/moi_front.sv
rtl/moi_lane.sv
rtl/mecanum_odometry_integrator_unit.sv
rtl/moi_checker.sv
sim/tb_mecanum_odometry_integrator_unit.sv
